FILE: src/tcpu_pkg.sv
// Shared types, phase and opcode codes, and the ALU function of the 8-bit cycle core.
package tcpu_pkg;

  localparam int unsigned AddrBitsDef = 16;
  localparam int unsigned AddrOutW    = 16;
  localparam int unsigned DataW       = 8;
  localparam int unsigned NumRegs     = 4;
  localparam int unsigned RegIdxW     = 2;
  localparam int unsigned OutTdataW   = 32;

  // Phase codes
  localparam logic [2:0] PhFetch0 = 3'd0;
  localparam logic [2:0] PhFetch1 = 3'd1;
  localparam logic [2:0] PhJump   = 3'd2;
  localparam logic [2:0] PhLoad   = 3'd3;
  localparam logic [2:0] PhLoad1  = 3'd4;
  localparam logic [2:0] PhStore  = 3'd5;
  localparam logic [2:0] PhImm    = 3'd6;
  localparam logic [2:0] PhHalt   = 3'd7;

  // Major opcode, bits 7:6 of the first byte
  localparam logic [1:0] MajAlu   = 2'b00;
  localparam logic [1:0] MajJump  = 2'b01;
  localparam logic [1:0] MajLoad  = 2'b10;
  localparam logic [1:0] MajStore = 2'b11;

  // ALU operations
  localparam logic [1:0] AluAdd = 2'd0;
  localparam logic [1:0] AluSub = 2'd1;
  localparam logic [1:0] AluAnd = 2'd2;
  localparam logic [1:0] AluOr  = 2'd3;

  localparam logic [3:0] IoNibble = 4'h0;
  localparam logic [7:0] IoLimit  = 8'd16;

  typedef struct packed {
    logic [NumRegs-1:0][DataW-1:0] reg_file;
    logic [2:0]                    phase;
    logic [RegIdxW-1:0]            mem_reg_sel;
    logic [RegIdxW-1:0]            imm_target;
    logic [RegIdxW-1:0]            imm_opcode;
    logic [RegIdxW-1:0]            load_dest;
    logic [3:0]                    addr_hi;
    logic [AddrOutW-1:0]           addr_hold;
    logic [DataW-1:0]              wdata_hold;
  } core_state_t;

  typedef struct packed {
    logic                halted;
    logic [DataW-1:0]    data_out;
    logic [AddrOutW-1:0] address;
    logic                write_enable;
    logic                io_select;
    logic                mem_select;
  } bus_result_t;

  function automatic logic [DataW-1:0] alu_op(input logic [1:0] op,
                                              input logic [DataW-1:0] a,
                                              input logic [DataW-1:0] b);
    logic [DataW-1:0] r;
    unique case (op)
      AluAdd:  r = a + b;
      AluSub:  r = a - b;
      AluAnd:  r = a & b;
      AluOr:   r = a | b;
      default: r = a | b;
    endcase
    return r;
  endfunction

endpackage

FILE: src/tiny_8bit_cpu_cycle_core_unit.sv
// An accepted request goes from the input register through the combinational step logic
// into the result register on the master side. Throughput: one request per cycle while
// the result register is free or being drained; a stall on the master side holds it.
// Reset: rst_ni clears the register file, pc, the phase (fetch first byte),
// all operand latches and both valid flags.
module tiny_8bit_cpu_cycle_core_unit #(
  parameter int unsigned ADDR_BITS = tcpu_pkg::AddrBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] data_in
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] mem_select, [1] io_select, [2] write_enable, [18:3] address,
  // [26:19] data_out, [27] halted, [31:28] zero
  output logic [tcpu_pkg::OutTdataW-1:0]  m_axis_tdata_o
);
  import tcpu_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           in_data_q;
  logic                 out_valid_q;
  bus_result_t          out_res_q;
  core_state_t          state_q, state_d;
  logic [ADDR_BITS-1:0] pc_q, pc_d;
  bus_result_t          res_d;
  logic                 advance;

  // step the core when the result register is free or being drained
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  tcpu_step #(
    .ADDR_BITS(ADDR_BITS)
  ) u_step (
    .state_i (state_q),
    .pc_i    (pc_q),
    .data_i  (in_data_q),
    .state_o (state_d),
    .pc_o    (pc_d),
    .result_o(res_d)
  );

  // all-zero state puts the phase at fetch first byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      pc_q        <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        pc_q        <= pc_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutTdataW - $bits(bus_result_t))'(0), out_res_q};

`ifndef ASSERT_OFF
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PhHalt |=> state_q.phase == PhHalt)
    else $error("core left halt without reset");

  a_one_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.mem_select && out_res_q.io_select))
    else $error("memory and I/O selected together");

  a_store_selects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.write_enable) |->
      (out_res_q.mem_select || out_res_q.io_select))
    else $error("store without an address space");

  a_input_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_data_q)))
    else $error("pending request lost");
`endif

endmodule

FILE: src/tcpu_step.sv
// Next-state and bus-output logic for one processor cycle.
module tcpu_step #(
  parameter int unsigned ADDR_BITS = tcpu_pkg::AddrBitsDef
) (
  input  tcpu_pkg::core_state_t  state_i,
  input  logic [ADDR_BITS-1:0]   pc_i,
  input  logic [7:0]             data_i,
  output tcpu_pkg::core_state_t  state_o,
  output logic [ADDR_BITS-1:0]   pc_o,
  output tcpu_pkg::bus_result_t  result_o
);
  import tcpu_pkg::*;

  logic [ADDR_BITS-1:0] pc_inc1;
  logic [ADDR_BITS-1:0] pc_inc2;
  logic [AddrOutW-1:0]  far_addr;
  logic                 is_io;
  logic [1:0]           tgt;
  logic [1:0]           src;

  assign pc_inc1  = pc_i + ADDR_BITS'(1);
  assign pc_inc2  = pc_i + ADDR_BITS'(2);
  assign far_addr = {4'h0, state_i.addr_hi, data_i};
  assign is_io    = (state_i.addr_hi == IoNibble) && (data_i < IoLimit);
  assign tgt      = data_i[3:2];
  assign src      = data_i[1:0];

  always_comb begin
    state_o  = state_i;
    pc_o     = pc_i;
    result_o = '0;
    result_o.halted = (state_i.phase == PhHalt);

    unique case (state_i.phase)
      PhFetch0: begin
        result_o.mem_select = 1'b1;
        state_o.addr_hold   = AddrOutW'(pc_i);
        state_o.phase       = PhFetch1;
      end
      PhFetch1: begin
        if (data_i == '0) begin
          state_o.phase = PhHalt;
        end else if (data_i[7:6] == MajAlu && data_i[5:4] != 2'b00) begin
          // register-to-register ALU finishes in decode
          state_o.reg_file[tgt] = alu_op(data_i[5:4], state_i.reg_file[tgt],
                                         state_i.reg_file[src]);
          pc_o          = pc_inc1;
          state_o.phase = PhFetch0;
        end else begin
          result_o.mem_select = 1'b1;
          state_o.addr_hold   = AddrOutW'(pc_inc1);
          unique case (data_i[7:6])
            MajStore: state_o.phase = PhStore;
            MajLoad:  state_o.phase = PhLoad;
            MajJump:  state_o.phase = PhJump;
            default:  state_o.phase = PhImm;
          endcase
        end
      end
      PhJump: begin
        pc_o          = pc_inc2;
        state_o.phase = PhFetch0;
      end
      PhLoad: begin
        pc_o                = pc_inc2;
        result_o.io_select  = is_io;
        result_o.mem_select = !is_io;
        state_o.addr_hold   = far_addr;
        state_o.phase       = PhLoad1;
      end
      PhLoad1: begin
        state_o.reg_file[state_i.load_dest] = data_i;
        state_o.phase = PhFetch0;
      end
      PhStore: begin
        pc_o                  = pc_inc2;
        result_o.io_select    = is_io;
        result_o.mem_select   = !is_io;
        result_o.write_enable = 1'b1;
        state_o.addr_hold     = far_addr;
        state_o.wdata_hold    = state_i.reg_file[state_i.mem_reg_sel];
        state_o.phase         = PhFetch0;
      end
      PhImm: begin
        pc_o = pc_inc2;
        state_o.reg_file[state_i.imm_target] =
          alu_op(state_i.imm_opcode, state_i.reg_file[state_i.imm_target], data_i);
        state_o.phase = PhFetch0;
      end
      default: begin
        // halt: hold registers, pc and phase
      end
    endcase

    // latch operand fields every cycle
    state_o.mem_reg_sel = data_i[5:4];
    state_o.imm_opcode  = data_i[5:4];
    state_o.imm_target  = data_i[3:2];
    state_o.addr_hi     = data_i[3:0];
    state_o.load_dest   = state_i.mem_reg_sel;

    result_o.address  = state_o.addr_hold;
    result_o.data_out = state_o.wdata_hold;
  end

endmodule

FILE: sim/tiny_8bit_cpu_cycle_core_unit_test.sv
// Stream testbench for the 8-bit cycle core: instruction streams in, bus cycles checked out.
module tiny_8bit_cpu_cycle_core_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpu_pkg::*;

  localparam int unsigned AddrBits   = AddrBitsDef;
  localparam int unsigned ResW       = $bits(bus_result_t);
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned PrintLimit = 20;
  localparam int unsigned PhaseItems = 420;

  typedef enum int {
    KindRegAlu, KindImm, KindLoad, KindStore, KindJump, KindRaw
  } instr_kind_e;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i  = '0;  // [7:0] data_in
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // [0] mem_select, [1] io_select, [2] write_enable, [18:3] address,
  // [26:19] data_out, [27] halted, [31:28] zero
  logic [OutTdataW-1:0] m_axis_tdata_o;

  tiny_8bit_cpu_cycle_core_unit #(
    .ADDR_BITS(AddrBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Bus bytes waiting to be offered, and bus cycles the core owes us
  logic [7:0]  bus_bytes_q[$];
  bus_result_t pending_bus_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned quiet_cycles = 0;

  int unsigned mismatches = 0;
  int unsigned cycles_sent = 0;
  int unsigned results_seen = 0;
  int unsigned n_reg_alu = 0, n_imm = 0, n_jumps = 0, n_pc_wraps = 0;
  int unsigned n_loads = 0, n_io_loads = 0, n_stores = 0, n_io_stores = 0;
  int unsigned n_halted = 0;

  // Core state as the predictor sees it
  logic [7:0]          cpu_regs[NumRegs];
  logic [2:0]          cpu_phase = PhFetch0;
  logic [AddrBits-1:0] cpu_pc = '0;
  logic [1:0]          cpu_mem_sel = '0, cpu_imm_tgt = '0, cpu_imm_op = '0;
  logic [1:0]          cpu_load_dest = '0;
  logic [3:0]          cpu_nib = '0;
  logic [AddrOutW-1:0] cpu_addr = '0;
  logic [7:0]          cpu_wdata = '0;

  initial foreach (cpu_regs[i]) cpu_regs[i] = '0;

  function automatic logic [7:0] alu_result(input logic [1:0] op, input logic [7:0] a,
                                            input logic [7:0] b);
    case (op)
      AluAdd:  return a + b;
      AluSub:  return a - b;
      AluAnd:  return a & b;
      default: return a | b;
    endcase
  endfunction

  // Advance the core by one bus cycle and queue the bus outputs it must show
  task automatic predict_bus_cycle(input logic [7:0] d);
    bus_result_t         r;
    logic [2:0]          nxt_phase;
    logic [AddrBits-1:0] nxt_pc;
    logic [AddrBits-1:0] pc_plus1;
    logic                io_hit;
    r         = '0;
    r.halted  = (cpu_phase == PhHalt);
    nxt_phase = cpu_phase;
    nxt_pc    = cpu_pc;
    pc_plus1  = cpu_pc + 1'b1;
    io_hit    = (cpu_nib == IoNibble) && (d < IoLimit);
    case (cpu_phase)
      PhFetch0: begin
        r.mem_select = 1'b1;
        cpu_addr     = AddrOutW'(cpu_pc);
        nxt_phase    = PhFetch1;
      end
      PhFetch1: begin
        if (d == 8'h00) begin
          nxt_phase = PhHalt;
        end else if (d[7:6] == MajAlu && d[5:4] != 2'b00) begin
          cpu_regs[d[3:2]] = alu_result(d[5:4], cpu_regs[d[3:2]], cpu_regs[d[1:0]]);
          nxt_pc    = pc_plus1;
          nxt_phase = PhFetch0;
          n_reg_alu++;
        end else begin
          r.mem_select = 1'b1;
          cpu_addr     = AddrOutW'(pc_plus1);
          case (d[7:6])
            MajStore: nxt_phase = PhStore;
            MajLoad:  nxt_phase = PhLoad;
            MajJump:  nxt_phase = PhJump;
            default:  nxt_phase = PhImm;
          endcase
        end
      end
      PhJump: begin
        nxt_pc    = cpu_pc + 2'd2;
        nxt_phase = PhFetch0;
        n_jumps++;
      end
      PhLoad: begin
        nxt_pc       = cpu_pc + 2'd2;
        r.io_select  = io_hit;
        r.mem_select = !io_hit;
        cpu_addr     = AddrOutW'({cpu_nib, d});
        nxt_phase    = PhLoad1;
        n_loads++;
        if (io_hit) n_io_loads++;
      end
      PhLoad1: begin
        cpu_regs[cpu_load_dest] = d;
        nxt_phase = PhFetch0;
      end
      PhStore: begin
        nxt_pc         = cpu_pc + 2'd2;
        r.io_select    = io_hit;
        r.mem_select   = !io_hit;
        r.write_enable = 1'b1;
        cpu_addr       = AddrOutW'({cpu_nib, d});
        cpu_wdata      = cpu_regs[cpu_mem_sel];
        nxt_phase      = PhFetch0;
        n_stores++;
        if (io_hit) n_io_stores++;
      end
      PhImm: begin
        nxt_pc    = cpu_pc + 2'd2;
        cpu_regs[cpu_imm_tgt] = alu_result(cpu_imm_op, cpu_regs[cpu_imm_tgt], d);
        nxt_phase = PhFetch0;
        n_imm++;
      end
      default: n_halted++;
    endcase
    // Operand latches load on every cycle; load_dest takes the old register select
    cpu_load_dest = cpu_mem_sel;
    cpu_mem_sel   = d[5:4];
    cpu_imm_op    = d[5:4];
    cpu_imm_tgt   = d[3:2];
    cpu_nib       = d[3:0];
    if (nxt_pc < cpu_pc) n_pc_wraps++;
    cpu_phase = nxt_phase;
    cpu_pc    = nxt_pc;
    r.address  = cpu_addr;
    r.data_out = cpu_wdata;
    pending_bus_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PrintLimit)
      $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
               what, results_seen, got, want);
    mismatches++;
  endtask

  // Queue one instruction: fetch byte, opcode byte, then the operand cycles it takes
  task automatic push_instr(input logic [7:0] op, input logic [7:0] operand,
                            input logic [7:0] read_data);
    bus_bytes_q.push_back(8'($urandom));
    bus_bytes_q.push_back(op);
    if (op == 8'h00) return;
    if (!(op[7:6] == MajAlu && op[5:4] != 2'b00)) begin
      bus_bytes_q.push_back(operand);
      if (op[7:6] == MajLoad) bus_bytes_q.push_back(read_data);
    end
  endtask

  task automatic push_random_instr();
    logic [7:0] op;
    logic [7:0] operand;
    operand = 8'($urandom);
    case (instr_kind_e'($urandom_range(KindRaw, KindRegAlu)))
      KindRegAlu: op = {MajAlu, 2'($urandom_range(3, 1)), 4'($urandom)};
      KindImm:    op = {MajAlu, 2'b00, 4'($urandom_range(15, 1))};
      KindLoad:   op = {MajLoad, 6'($urandom)};
      KindStore:  op = {MajStore, 6'($urandom)};
      KindJump:   op = {MajJump, 6'($urandom)};
      default:    op = 8'($urandom_range(255, 1));
    endcase
    // Steer a third of the memory accesses near the I/O boundary
    if (op[7] && $urandom_range(2) == 0) begin
      op[3:0] = IoNibble;
      operand = 8'($urandom_range(31, 0));
    end
    push_instr(op, operand, 8'($urandom));
  endtask

  task automatic fill_random(input int unsigned count);
    int unsigned target;
    target = bus_bytes_q.size() + count;
    while (bus_bytes_q.size() < target) push_random_instr();
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (bus_bytes_q.size() != 0 || s_axis_tvalid_i || pending_bus_q.size() != 0);
  endtask

  // Request side: offer queued bytes, hold a request until it is taken
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic       nxt_valid;
    logic [7:0] nxt_data;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      nxt_valid = s_axis_tvalid_i;
      nxt_data  = s_axis_tdata_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_bus_cycle(s_axis_tdata_i);
        cycles_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && bus_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data  = bus_bytes_q.pop_front();
      end
      s_axis_tvalid_i <= nxt_valid;
      s_axis_tdata_i  <= nxt_data;
    end
  end

  // Long receiver hold-off, started once per request from the stimulus
  always @(posedge clk_i or negedge rst_ni) begin : hold_counter
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (holds_done != holds_asked) begin
      hold_left  <= HoldCycles;
      holds_done <= holds_done + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : bus_monitor
    bus_result_t got;
    bus_result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = bus_result_t'(m_axis_tdata_o[ResW-1:0]);
        if (m_axis_tdata_o[OutTdataW-1:ResW] != '0)
          report_mismatch("pad bits", 32'(m_axis_tdata_o[OutTdataW-1:ResW]), 32'd0);
        if (pending_bus_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(got), 32'd0);
        end else begin
          want = pending_bus_q.pop_front();
          if (got.mem_select !== want.mem_select)
            report_mismatch("mem_select", 32'(got.mem_select), 32'(want.mem_select));
          if (got.io_select !== want.io_select)
            report_mismatch("io_select", 32'(got.io_select), 32'(want.io_select));
          if (got.write_enable !== want.write_enable)
            report_mismatch("write_enable", 32'(got.write_enable), 32'(want.write_enable));
          if (got.address !== want.address)
            report_mismatch("address", 32'(got.address), 32'(want.address));
          if (got.data_out !== want.data_out)
            report_mismatch("data_out", 32'(got.data_out), 32'(want.data_out));
          if (got.halted !== want.halted)
            report_mismatch("halted", 32'(got.halted), 32'(want.halted));
        end
        results_seen++;
      end
      m_axis_tready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("no transfer for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every ALU op, immediate extremes, I/O and memory edges, a jump
    set_idling(0, 0);
    push_instr({MajAlu, 2'b00, 4'h1}, 8'hFF, 8'h00);    // r0 += 0xff
    push_instr({MajAlu, 2'b00, 4'h4}, 8'h80, 8'h00);    // r1 += 0x80
    push_instr({MajAlu, AluSub, 2'd2, 2'd0}, 8'h00, 8'h00);
    push_instr({MajAlu, AluAnd, 2'd3, 2'd1}, 8'h00, 8'h00);
    push_instr({MajAlu, AluOr, 2'd0, 2'd3}, 8'h00, 8'h00);
    push_instr({MajStore, 2'd0, IoNibble}, 8'h0F, 8'h00); // last I/O address
    push_instr({MajStore, 2'd3, 4'hF}, 8'hFF, 8'h00);     // top of memory
    push_instr({MajStore, 2'd2, IoNibble}, IoLimit, 8'h00); // first memory address
    push_instr({MajLoad, 2'd1, IoNibble}, 8'h00, 8'hFF);
    push_instr({MajLoad, 2'd3, 4'hF}, 8'hFF, 8'h00);
    push_instr({MajJump, 6'h3F}, 8'hAA, 8'h00);
    wait_idle();

    set_idling(0, 0);
    fill_random(PhaseItems);
    wait_idle();
    set_idling(80, 0);
    fill_random(PhaseItems);
    wait_idle();
    set_idling(0, 80);
    fill_random(PhaseItems);
    wait_idle();
    set_idling(17, 17);
    fill_random(PhaseItems);
    wait_idle();

    // Back-pressure: keep offering while the receiver is held off
    set_idling(0, 0);
    fill_random(150);
    holds_asked = holds_asked + 1;
    wait_idle();

    fill_random(40);
    wait_idle();

    // Halt is sticky, so it comes last; the trailing cycles must all show halted
    push_instr(8'h00, 8'h00, 8'h00);
    repeat (4) bus_bytes_q.push_back(8'($urandom));
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (pending_bus_q.size() != 0)
      report_mismatch("missing results", pending_bus_q.size(), 32'd0);
    $display("ran %0d bus cycles, checked %0d results, %0d mismatches",
             cycles_sent, results_seen, mismatches);
    $display("reg alu %0d, imm %0d, loads %0d (io %0d), stores %0d (io %0d)",
             n_reg_alu, n_imm, n_loads, n_io_loads, n_stores, n_io_stores);
    $display("jumps %0d, pc wraps %0d, halted cycles %0d", n_jumps, n_pc_wraps, n_halted);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tcpu_pkg.sv
src/tcpu_step.sv
src/tiny_8bit_cpu_cycle_core_unit.sv
sim/tiny_8bit_cpu_cycle_core_unit_test.sv
